FILE: sv/itbd_pkg.sv
// ----------------------------------------------------------------------------
// itbd_pkg
// Shared constants and helpers for the integer to base-digit text converter.
// ----------------------------------------------------------------------------
package itbd_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DIGIT_W         = 6;
    localparam int STEP_BITS       = 4;

    localparam logic [DIGIT_W-1:0] RADIX_RESET   = 6'd10;
    localparam logic [DIGIT_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd10;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_SIGN,
        S_READ,
        S_LOAD
    } t_state;

    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] c;
        if (d >= DECIMAL_LIMIT) begin
            c = CHAR_A + 8'(d) - 8'(DECIMAL_LIMIT);
        end else begin
            c = CHAR_ZERO + 8'(d);
        end
        return c;
    endfunction

endpackage

FILE: sv/int_to_base_digits.sv
// ----------------------------------------------------------------------------
// int_to_base_digits
// Converts a signed integer to ASCII digits in a configured base, sign first,
// most significant digit first, is_last on the final character.
// ----------------------------------------------------------------------------
// each digit is one divider run, started in S_START and awaited in S_DIV,
//   the divider producing 4 quotient bits per cycle while it is busy;
// then the sign state and, per character, a digit store read and an output load
// one value is in flight at a time, its digits all using the shared divider;
//   input stalls until the last character is loaded
// reset: synchronous active low; radix returns to 10, digit store is not cleared
module int_to_base_digits #(
    parameter int VALUE_WIDTH = itbd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [itbd_pkg::DIGIT_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_character,
    output logic                          o_is_last
);
    import itbd_pkg::*;

    localparam int AW = $clog2(VALUE_WIDTH);

    t_state             r_state;
    t_state             n_state;
    logic [DIGIT_W-1:0] r_radix;
    logic [DIGIT_W-1:0] r_rdx;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic               r_neg;
    logic [AW-1:0]      r_cnt;
    logic               r_out_valid;
    logic [7:0]         r_char;
    logic               r_last;

    logic [VALUE_WIDTH-1:0] w_val;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic [DIGIT_W-1:0]     w_rdx;
    logic                   w_out_free;
    logic                   w_div_start;
    logic                   w_div_busy;
    logic                   w_div_done;
    logic [VALUE_WIDTH-1:0] w_quo;
    logic [DIGIT_W-1:0]     w_rem;
    logic                   w_we;
    logic                   w_re;
    logic [DIGIT_W-1:0]     w_rdata;
    logic                   w_more;
    logic                   w_accept;

    assign w_val      = $unsigned(i_value);
    assign w_mag      = w_val[VALUE_WIDTH-1] ? (~w_val + 1'b1) : w_val;
    assign w_rdx      = (r_radix < RADIX_MIN) ? RADIX_MIN :
                        (r_radix > RADIX_MAX) ? RADIX_MAX : r_radix;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    // another digit follows unless the quotient ran out or the store is full
    assign w_more     = (w_quo != '0) && (r_cnt != AW'(VALUE_WIDTH - 1));

    itbd_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_mag),
        .i_divisor  (r_rdx),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo),
        .o_remainder(w_rem)
    );

    itbd_ram #(
        .WIDTH(DIGIT_W),
        .DEPTH(VALUE_WIDTH)
    ) u_digit_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_cnt),
        .i_wdata(w_rem),
        .i_re   (w_re),
        .i_raddr(r_cnt),
        .o_rdata(w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = w_more ? S_START : S_SIGN;
                end
            end
            S_SIGN: begin
                if (!r_neg || w_out_free) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (w_out_free) begin
                    n_state = (r_cnt == '0) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall  = 1'b1;
        w_div_start = 1'b0;
        w_we        = 1'b0;
        w_re        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_START: begin
                w_div_start = 1'b1;
            end
            S_DIV: begin
                w_we = w_div_done;
            end
            S_READ: begin
                w_re = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix     <= RADIX_RESET;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_radix <= i_cfg_data;
            end
            if (w_accept) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV && w_div_done && w_more) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (r_state == S_LOAD && w_out_free && r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if ((r_state == S_SIGN && r_neg && w_out_free) ||
                (r_state == S_LOAD && w_out_free)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mag <= w_mag;
            r_neg <= w_val[VALUE_WIDTH-1];
            r_rdx <= w_rdx;
        end else if (r_state == S_DIV && w_div_done) begin
            r_mag <= w_quo;
        end
        if (r_state == S_SIGN && r_neg && w_out_free) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end else if (r_state == S_LOAD && w_out_free) begin
            r_char <= digit_char(w_rdata);
            r_last <= (r_cnt == '0);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_is_last   = r_last;

`ifndef SYNTHESIS
    // a new item never enters while the divider is still working
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !w_div_busy)
        else $error("item accepted while divider busy");

    // a finished division always moves the sequencer on
    a_div_done_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && w_div_done) |=> (r_state == S_START || r_state == S_SIGN))
        else $error("sequencer stuck after division");

    // the sign character never closes a number
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> (r_char != CHAR_MINUS))
        else $error("minus sign flagged as last character");
`endif

endmodule

FILE: sv/itbd_ram.sv
// ----------------------------------------------------------------------------
// itbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/itbd_div.sv
// ----------------------------------------------------------------------------
// itbd_div
// Iterative divider of a wide unsigned value by a small radix, several
// quotient bits per cycle.
// ----------------------------------------------------------------------------
module itbd_div #(
    parameter int VALUE_WIDTH = itbd_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [VALUE_WIDTH-1:0]       i_dividend,
    input  logic [itbd_pkg::DIGIT_W-1:0] i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [VALUE_WIDTH-1:0]       o_quotient,
    output logic [itbd_pkg::DIGIT_W-1:0] o_remainder
);
    import itbd_pkg::*;

    localparam int STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PADW  = STEPS * STEP_BITS;
    localparam int CW    = $clog2(STEPS + 1);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [PADW-1:0]    r_num;
    logic [DIGIT_W-1:0] r_rem;
    logic [DIGIT_W-1:0] r_div;
    logic [PADW-1:0]    n_num;
    logic [DIGIT_W-1:0] n_rem;

    // remaining dividend shifts out at the top, quotient bits shift in below
    always_comb begin
        logic [DIGIT_W:0] t;
        n_num = r_num;
        n_rem = r_rem;
        for (int k = 0; k < STEP_BITS; k++) begin
            t     = {n_rem, n_num[PADW-1]};
            n_num = {n_num[PADW-2:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                n_rem    = DIGIT_W'(t - {1'b0, r_div});
                n_num[0] = 1'b1;
            end else begin
                n_rem = t[DIGIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= PADW'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_num[VALUE_WIDTH-1:0];
    assign o_remainder = r_rem;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer to base-digit text converter: signed
// values go in under several radix settings (saturating ones included), every
// character is predicted and compared in order, with random gaps and stalls on
// both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import itbd_pkg::*;

    localparam int VW        = VALUE_WIDTH_DEF;
    localparam int CYCLE_CAP = 1000000;
    localparam int HOLD_LEN  = 600;

    typedef struct {
        logic [7:0] character;
        logic       is_last;
    } t_char_exp;

    // predicts the text of each accepted value and checks it char by char
    class digit_text_scoreboard;
        logic [DIGIT_W-1:0] radix;
        t_char_exp          text_queue[$];
        int                 n_fail;

        function new();
            radix  = RADIX_RESET;
            n_fail = 0;
        endfunction

        function void note_value(logic signed [VW-1:0] value);
            logic [DIGIT_W-1:0] base;
            logic [VW-1:0]      mag;
            logic [DIGIT_W-1:0] digits[$];
            t_char_exp          e;
            base = radix;
            if (base < RADIX_MIN) begin
                base = RADIX_MIN;
            end else if (base > RADIX_MAX) begin
                base = RADIX_MAX;
            end
            // most negative value wraps to its own unsigned magnitude
            mag = value[VW-1] ? VW'(~value + 1'b1) : VW'(value);
            do begin
                digits.push_front(DIGIT_W'(mag % VW'(base)));
                mag = mag / VW'(base);
            end while (mag != 0);
            if (value[VW-1]) begin
                e.character = CHAR_MINUS;
                e.is_last   = 1'b0;
                text_queue.push_back(e);
            end
            foreach (digits[i]) begin
                if (digits[i] < DECIMAL_LIMIT) begin
                    e.character = CHAR_ZERO + 8'(digits[i]);
                end else begin
                    e.character = CHAR_A + 8'(digits[i]) - 8'(DECIMAL_LIMIT);
                end
                e.is_last = (i == digits.size() - 1);
                text_queue.push_back(e);
            end
        endfunction

        function void check_char(logic [7:0] character, logic is_last);
            t_char_exp e;
            if (text_queue.size() == 0) begin
                $error("character 0x%02h with no item outstanding", character);
                n_fail++;
                return;
            end
            e = text_queue.pop_front();
            if (character !== e.character) begin
                $error("character: expected 0x%02h, got 0x%02h", e.character, character);
                n_fail++;
            end
            if (is_last !== e.is_last) begin
                $error("is_last: expected %0d, got %0d", e.is_last, is_last);
                n_fail++;
            end
        endfunction

        function int waiting();
            return text_queue.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [DIGIT_W-1:0]    i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic signed [VW-1:0]  i_value;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [7:0]            o_character;
    logic                  o_is_last;

    digit_text_scoreboard  sb;
    bit                    idle_on;
    bit                    hold_req;
    bit                    hold_done;
    int                    hold_left;
    int                    cycles;

    int_to_base_digits #(.VALUE_WIDTH(VW)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_character (o_character),
        .o_is_last   (o_is_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_CAP) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        hold_left = 0;
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= idle_on && ($urandom_range(99) < 17);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_char(o_character, o_is_last);
        end
    end

    function automatic logic [VW-1:0] rand_value();
        int            pick;
        int            nbits;
        logic [VW-1:0] v;
        pick = $urandom_range(99);
        v    = $urandom;
        if (pick < 40) begin
            // full range as is
        end else if (pick < 60) begin
            v = $urandom_range(1000);
            if ($urandom_range(1)) v = -v;
        end else if (pick < 75) begin
            if ($urandom_range(1)) begin
                v = {1'b0, {(VW-1){1'b1}}} - $urandom_range(40);
            end else begin
                v = {1'b1, {(VW-1){1'b0}}} + $urandom_range(40);
            end
        end else begin
            nbits = $urandom_range(1, VW - 1);
            v     = v & ((VW'(1) << nbits) - 1'b1);
            if ($urandom_range(1)) v = -v;
        end
        return v;
    endfunction

    task automatic send_value(input logic [VW-1:0] v);
        while (idle_on && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_value(v);
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++) begin
            send_value(rand_value());
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.waiting() != 0) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [DIGIT_W-1:0] r);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= r;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.radix = r;
    endtask

    initial begin
        sb       = new();
        idle_on  = 1'b1;
        hold_req = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_value     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset radix is decimal
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(9);
        send_value(10);
        send_value(-10);
        send_value(32'sh7fffffff);
        send_value(32'sh80000000);
        send_value(32'sh55555555);
        send_value(32'shaaaaaaaa);
        send_random(30);

        // binary: most negative value gives the longest text
        write_radix(6'd2);
        hold_req = 1'b1;
        send_value(32'sh80000000);
        send_value(32'sh7fffffff);
        send_value(-1);
        send_random(35);

        // top base, with a long stretch of no idling on either side
        write_radix(6'd36);
        idle_on = 1'b0;
        send_value(35);
        send_value(36);
        send_value(-1295);
        send_value(32'sh80000000);
        send_random(35);
        idle_on = 1'b1;

        write_radix(6'd16);
        send_random(30);

        // out-of-range settings saturate
        write_radix(6'd0);
        send_value(5);
        send_random(25);

        write_radix(6'd63);
        send_value(36);
        send_random(25);

        write_radix(6'd1);
        send_random(25);

        write_radix(6'd37);
        send_random(25);

        write_radix(6'($urandom_range(3, 35)));
        send_random(30);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (sb.waiting() != 0) begin
            $error("%0d characters never arrived", sb.waiting());
            sb.n_fail++;
        end
        if (sb.n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
